// ===== rtl/tssf_pkg.sv =====
// Shared types and constants for the triangle scanline span filler.
`timescale 1ns / 1ps

package tssf_pkg;

  localparam int FIELD_BITS  = 6;
  localparam int SYMBOL_BITS = 8;

  typedef struct packed {
    logic [FIELD_BITS-1:0] x;
    logic [FIELD_BITS-1:0] y;
  } vertex_t;

endpackage

// ===== rtl/tssf_sort.sv =====
// Three-step compare-and-swap network that orders three vertices by row.
`timescale 1ns / 1ps

module tssf_sort (
  input  tssf_pkg::vertex_t a,
  input  tssf_pkg::vertex_t b,
  input  tssf_pkg::vertex_t c,
  output tssf_pkg::vertex_t sa,
  output tssf_pkg::vertex_t sb,
  output tssf_pkg::vertex_t sc
);

  tssf_pkg::vertex_t p1_a;
  tssf_pkg::vertex_t p1_b;
  tssf_pkg::vertex_t p2_b;

  always_comb begin
    if (a.y > b.y) begin
      p1_a = b;
      p1_b = a;
    end else begin
      p1_a = a;
      p1_b = b;
    end
    if (p1_b.y > c.y) begin
      p2_b = c;
      sc   = p1_b;
    end else begin
      p2_b = p1_b;
      sc   = c;
    end
    if (p1_a.y > p2_b.y) begin
      sa = p2_b;
      sb = p1_a;
    end else begin
      sa = p1_a;
      sb = p2_b;
    end
  end

endmodule

// ===== rtl/tssf_divider.sv =====
// Restoring divider, one quotient bit per cycle, giving num / den rounded half up.
`timescale 1ns / 1ps

module tssf_divider #(
  parameter int CB = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [2*CB-1:0] num,
  input  logic [CB-1:0]   den,
  output logic            done,
  output logic [CB-1:0]   quo
);

  localparam int RW = 2 * CB + 1;
  localparam int CW = $clog2(CB);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [RW-1:0] rem;
  logic [RW-1:0] dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CW'(CB - 1);
      rem  <= {num, 1'b0} + RW'(den);
      dsh  <= RW'({den, 1'b0}) << (CB - 1);
      quo  <= '0;
    end else if (busy) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
        quo <= {quo[CB-2:0], 1'b1};
      end else begin
        quo <= {quo[CB-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

// ===== rtl/triangle_scanline_span_fill.sv =====
// Top level of the triangle scanline span filler: sequencer, edge state and output register.
//
//   channel   direction  handshake            beat
//   triangle  in         in_valid, in_stall   fill_symbol, vertex_a/b/c_x/y
//   span      out        out_valid, out_stall span_row, span_left, span_right,
//                                             span_symbol, last_span
//
// One triangle starts with setup in S_INIT_L and, unless it is flat, S_INIT_S; then the
// shared divider evaluates both edge positions of each row in turn, except on a flat
// last row, whose ends come from the vertices. A triangle covers up to 2^COORD_BITS rows.
// in_stall stays high from the accepted beat until the last span is loaded into the
// output register; a stalled output holds the sequencer in its emit state.
// Reset is synchronous and leaves the block idle with no span pending.
`timescale 1ns / 1ps

module triangle_scanline_span_fill #(
  parameter int COORD_BITS = 6
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] fill_symbol,
  input  logic [5:0] vertex_a_x,
  input  logic [5:0] vertex_a_y,
  input  logic [5:0] vertex_b_x,
  input  logic [5:0] vertex_b_y,
  input  logic [5:0] vertex_c_x,
  input  logic [5:0] vertex_c_y,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] span_row,
  output logic [5:0] span_left,
  output logic [5:0] span_right,
  output logic [7:0] span_symbol,
  output logic       last_span
);

  localparam int CB = COORD_BITS;
  localparam int NW = 2 * CB;
  localparam int FB = tssf_pkg::FIELD_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT_L,
    S_INIT_S,
    S_DIV_L,
    S_WAIT_L,
    S_DIV_S,
    S_WAIT_S,
    S_EMIT
  } state_t;

  state_t state;

  tssf_pkg::vertex_t in_a;
  tssf_pkg::vertex_t in_b;
  tssf_pkg::vertex_t in_c;
  tssf_pkg::vertex_t srt_a;
  tssf_pkg::vertex_t srt_b;
  tssf_pkg::vertex_t srt_c;
  tssf_pkg::vertex_t va;
  tssf_pkg::vertex_t vb;
  tssf_pkg::vertex_t vc;

  logic [tssf_pkg::SYMBOL_BITS-1:0] sym;
  logic [CB-1:0] row;
  logic [CB-1:0] row_next;
  logic          upper;
  logic [NW-1:0] num_long;
  logic [NW-1:0] num_short;
  logic [CB:0]   dx_long;
  logic [CB:0]   dx_short;
  logic [CB-1:0] d_long;
  logic [CB-1:0] d_short;
  logic [CB-1:0] x_long;
  logic [CB-1:0] x_short;

  logic [CB-1:0] ax, ay, bx, by, cx, cy;
  logic [CB-1:0] min_ab, max_ab, min3, max3;
  logic [CB-1:0] span_lo, span_hi;

  logic [CB-1:0] mul_a;
  logic [CB-1:0] mul_b;
  logic [NW-1:0] mul_p;

  logic          div_start;
  logic [NW-1:0] div_num;
  logic [CB-1:0] div_den;
  logic          div_done;
  logic [CB-1:0] div_quo;

  logic accept;
  logic out_free;

  assign in_a = '{x: FB'(vertex_a_x[CB-1:0]), y: FB'(vertex_a_y[CB-1:0])};
  assign in_b = '{x: FB'(vertex_b_x[CB-1:0]), y: FB'(vertex_b_y[CB-1:0])};
  assign in_c = '{x: FB'(vertex_c_x[CB-1:0]), y: FB'(vertex_c_y[CB-1:0])};

  tssf_sort u_sort (
    .a  (in_a),
    .b  (in_b),
    .c  (in_c),
    .sa (srt_a),
    .sb (srt_b),
    .sc (srt_c)
  );

  assign ax = va.x[CB-1:0];
  assign ay = va.y[CB-1:0];
  assign bx = vb.x[CB-1:0];
  assign by = vb.y[CB-1:0];
  assign cx = vc.x[CB-1:0];
  assign cy = vc.y[CB-1:0];

  assign min_ab  = (bx < ax) ? bx : ax;
  assign max_ab  = (bx > ax) ? bx : ax;
  assign min3    = (cx < min_ab) ? cx : min_ab;
  assign max3    = (cx > max_ab) ? cx : max_ab;
  assign span_lo = (x_long < x_short) ? x_long : x_short;
  assign span_hi = (x_long < x_short) ? x_short : x_long;

  always_comb begin
    case (state)
      S_INIT_L: begin
        mul_a = ax;
        mul_b = cy - ay;
      end
      S_INIT_S: begin
        if (upper) begin
          mul_a = ax;
          mul_b = by - ay;
        end else begin
          mul_a = bx;
          mul_b = cy - by;
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign div_start = (state == S_DIV_L) || (state == S_DIV_S);
  assign div_num   = (state == S_DIV_L) ? num_long : num_short;
  assign div_den   = (state == S_DIV_L) ? d_long : d_short;

  tssf_divider #(
    .CB (CB)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign row_next = row + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            va    <= srt_a;
            vb    <= srt_b;
            vc    <= srt_c;
            sym   <= fill_symbol;
            row   <= srt_a.y[CB-1:0];
            upper <= (srt_a.y != srt_b.y);
            state <= S_INIT_L;
          end
        end
        S_INIT_L: begin
          if (ay == cy) begin
            x_long  <= min3;
            x_short <= max3;
            state   <= S_EMIT;
          end else begin
            num_long <= mul_p;
            d_long   <= cy - ay;
            dx_long  <= {1'b0, cx} - {1'b0, ax};
            state    <= S_INIT_S;
          end
        end
        S_INIT_S: begin
          num_short <= mul_p;
          d_short   <= mul_b;
          if (upper) begin
            dx_short <= {1'b0, bx} - {1'b0, ax};
          end else begin
            dx_short <= {1'b0, cx} - {1'b0, bx};
          end
          state <= S_DIV_L;
        end
        S_DIV_L: begin
          state <= S_WAIT_L;
        end
        S_WAIT_L: begin
          if (div_done) begin
            x_long <= div_quo;
            state  <= S_DIV_S;
          end
        end
        S_DIV_S: begin
          state <= S_WAIT_S;
        end
        S_WAIT_S: begin
          if (div_done) begin
            x_short <= div_quo;
            state   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            span_row    <= FB'(row);
            span_left   <= FB'(span_lo);
            span_right  <= FB'(span_hi);
            span_symbol <= sym;
            last_span   <= (row == cy);
            if (row == cy) begin
              state <= S_IDLE;
            end else begin
              row      <= row_next;
              num_long <= num_long + {{(NW-CB-1){dx_long[CB]}}, dx_long};
              if (upper && (row_next == by)) begin
                if (by == cy) begin
                  x_long  <= bx;
                  x_short <= cx;
                  state   <= S_EMIT;
                end else begin
                  upper <= 1'b0;
                  state <= S_INIT_S;
                end
              end else begin
                num_short <= num_short + {{(NW-CB-1){dx_short[CB]}}, dx_short};
                state     <= S_DIV_L;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/tssf_checker.sv =====
// Port-level checker for the triangle scanline span filler, bound to the top level.
`timescale 1ns / 1ps

module tssf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [5:0] span_row,
  input logic [5:0] span_left,
  input logic [5:0] span_right,
  input logic [7:0] span_symbol,
  input logic       last_span
);

  // An accepted triangle keeps the block busy in the cycle after its beat.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while block was still free on the next cycle");

  // While the block takes new triangles, only a final span may still be waiting.
  assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !(out_valid && !last_span))
    else $error("block idle with a non-final span pending");

  // After a non-final span leaves, the triangle is still in progress or its final
  // span has just been loaded.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_span |=> in_stall || (out_valid && last_span))
    else $error("block went idle before the final span");

  // A stalled span beat holds its contents.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(span_row) && $stable(span_left)
      && $stable(span_right) && $stable(span_symbol) && $stable(last_span))
    else $error("stalled span beat changed");

endmodule

bind triangle_scanline_span_fill tssf_checker u_tssf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .span_row    (span_row),
  .span_left   (span_left),
  .span_right  (span_right),
  .span_symbol (span_symbol),
  .last_span   (last_span)
);

// ===== dv/triangle_scanline_span_fill_tb.sv =====
// Self-checking testbench for the triangle scanline span filler.
`timescale 1ns / 1ps

module triangle_scanline_span_fill_tb;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT_SPAN = 60;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [tssf_pkg::SYMBOL_BITS-1:0] symbol;
    tssf_pkg::vertex_t a;
    tssf_pkg::vertex_t b;
    tssf_pkg::vertex_t c;
  } triangle_t;

  typedef struct packed {
    logic [tssf_pkg::FIELD_BITS-1:0] row;
    logic [tssf_pkg::FIELD_BITS-1:0] left;
    logic [tssf_pkg::FIELD_BITS-1:0] right;
    logic [tssf_pkg::SYMBOL_BITS-1:0] symbol;
    logic last;
  } span_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] fill_symbol = '0;
  logic [5:0] vertex_a_x = '0;
  logic [5:0] vertex_a_y = '0;
  logic [5:0] vertex_b_x = '0;
  logic [5:0] vertex_b_y = '0;
  logic [5:0] vertex_c_x = '0;
  logic [5:0] vertex_c_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [5:0] span_row;
  logic [5:0] span_left;
  logic [5:0] span_right;
  logic [7:0] span_symbol;
  logic last_span;

  triangle_t pending_triangles[$];
  span_t expected_spans[$];
  int sender_idle_pct = 25;
  int receiver_idle_pct = 81;
  int mismatches = 0;
  int spans_checked = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;

  triangle_scanline_span_fill u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .fill_symbol(fill_symbol),
    .vertex_a_x(vertex_a_x),
    .vertex_a_y(vertex_a_y),
    .vertex_b_x(vertex_b_x),
    .vertex_b_y(vertex_b_y),
    .vertex_c_x(vertex_c_x),
    .vertex_c_y(vertex_c_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .span_row(span_row),
    .span_left(span_left),
    .span_right(span_right),
    .span_symbol(span_symbol),
    .last_span(last_span)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Column where the edge from p to q crosses row y, exact and rounded half up.
  function automatic int edge_column(tssf_pkg::vertex_t p, tssf_pkg::vertex_t q, int y);
    int d;
    int num;
    d = int'(q.y) - int'(p.y);
    num = int'(p.x) * d + (int'(q.x) - int'(p.x)) * (y - int'(p.y));
    if (d <= 0 || num < 0) return int'(p.x);
    return (2 * num + d) / (2 * d);
  endfunction

  function automatic void queue_span(int row, int l, int r, logic [7:0] symbol, bit last);
    span_t s;
    s.row = row[5:0];
    s.left = (l < r) ? l[5:0] : r[5:0];
    s.right = (l < r) ? r[5:0] : l[5:0];
    s.symbol = symbol;
    s.last = last;
    expected_spans.push_back(s);
  endfunction

  function automatic void predict_spans(triangle_t t);
    tssf_pkg::vertex_t a;
    tssf_pkg::vertex_t b;
    tssf_pkg::vertex_t c;
    tssf_pkg::vertex_t swap;
    int lo;
    int hi;
    a = t.a;
    b = t.b;
    c = t.c;
    if (a.y > b.y) begin swap = a; a = b; b = swap; end
    if (b.y > c.y) begin swap = b; b = c; c = swap; end
    if (a.y > b.y) begin swap = a; a = b; b = swap; end
    if (a.y == c.y) begin
      lo = int'(a.x);
      hi = int'(a.x);
      if (int'(b.x) < lo) lo = int'(b.x);
      if (int'(c.x) < lo) lo = int'(c.x);
      if (int'(b.x) > hi) hi = int'(b.x);
      if (int'(c.x) > hi) hi = int'(c.x);
      queue_span(int'(a.y), lo, hi, t.symbol, 1'b1);
      return;
    end
    for (int y = int'(a.y); y < int'(b.y); y++)
      queue_span(y, edge_column(a, c, y), edge_column(a, b, y), t.symbol, 1'b0);
    if (b.y == c.y) begin
      queue_span(int'(b.y), int'(b.x), int'(c.x), t.symbol, 1'b1);
    end else begin
      for (int y = int'(b.y); y <= int'(c.y); y++)
        queue_span(y, edge_column(a, c, y), edge_column(b, c, y), t.symbol,
                   y == int'(c.y));
    end
  endfunction

  function automatic triangle_t make_triangle(int sym, int ax, int ay, int bx, int by,
                                              int cx, int cy);
    triangle_t t;
    t.symbol = sym[7:0];
    t.a.x = ax[5:0];
    t.a.y = ay[5:0];
    t.b.x = bx[5:0];
    t.b.y = by[5:0];
    t.c.x = cx[5:0];
    t.c.y = cy[5:0];
    return t;
  endfunction

  // Mostly short triangles so that each one costs few rows; the rest use any rows.
  function automatic triangle_t random_triangle();
    triangle_t t;
    int h;
    int base;
    t = make_triangle($urandom_range(255), $urandom_range(63), $urandom_range(63),
                      $urandom_range(63), $urandom_range(63), $urandom_range(63),
                      $urandom_range(63));
    if ($urandom_range(99) < 85) begin
      h = $urandom_range(7);
      base = $urandom_range(63 - h);
      t.a.y = 6'(base + $urandom_range(h));
      t.b.y = 6'(base + $urandom_range(h));
      t.c.y = 6'(base + $urandom_range(h));
    end
    case ($urandom_range(9))
      0: t.b.y = t.a.y;
      1: t.c.y = t.b.y;
      2: t.c.y = t.a.y;
      default: ;
    endcase
    return t;
  endfunction

  always @(posedge clk) begin
    triangle_t t;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        t = make_triangle(int'(fill_symbol), int'(vertex_a_x), int'(vertex_a_y),
                          int'(vertex_b_x), int'(vertex_b_y), int'(vertex_c_x),
                          int'(vertex_c_y));
        predict_spans(t);
      end
      if (!in_valid || !in_stall) begin
        if (pending_triangles.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          t = pending_triangles.pop_front();
          in_valid <= 1'b1;
          fill_symbol <= t.symbol;
          vertex_a_x <= t.a.x;
          vertex_a_y <= t.a.y;
          vertex_b_x <= t.b.x;
          vertex_b_y <= t.b.y;
          vertex_c_x <= t.c.x;
          vertex_c_y <= t.c.y;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    span_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_spans.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected span: row %0d left %0d right %0d symbol %0d last %0b",
                     span_row, span_left, span_right, span_symbol, last_span);
          mismatches++;
        end else begin
          want = expected_spans.pop_front();
          if (span_row !== want.row || span_left !== want.left ||
              span_right !== want.right || span_symbol !== want.symbol ||
              last_span !== want.last) begin
            if (mismatches < 10)
              $display("span mismatch: expected row %0d left %0d right %0d symbol %0d",
                       want.row, want.left, want.right, want.symbol,
                       " last %0b, got row %0d left %0d right %0d symbol %0d last %0b",
                       want.last, span_row, span_left, span_right, span_symbol,
                       last_span);
            mismatches++;
          end
        end
        spans_checked++;
        if (spans_checked == HOLD_AT_SPAN && !hold_done) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    pending_triangles.push_back(make_triangle(8'h00, 0, 0, 0, 0, 0, 0));
    pending_triangles.push_back(make_triangle(8'hFF, 30, 63, 0, 63, 63, 63));
    pending_triangles.push_back(make_triangle(8'hAA, 0, 0, 63, 0, 32, 63));
    pending_triangles.push_back(make_triangle(8'h55, 0, 63, 32, 0, 63, 63));
    pending_triangles.push_back(make_triangle(8'h01, 10, 0, 63, 30, 0, 63));
    pending_triangles.push_back(make_triangle(8'h80, 0, 63, 63, 30, 10, 0));
    pending_triangles.push_back(make_triangle(8'h7F, 63, 40, 63, 20, 0, 20));
    pending_triangles.push_back(make_triangle(8'h41, 5, 10, 50, 10, 20, 10));
    pending_triangles.push_back(make_triangle(8'h23, 0, 0, 3, 2, 0, 4));
    pending_triangles.push_back(make_triangle(8'h2A, 0, 0, 1, 2, 0, 2));
    pending_triangles.push_back(make_triangle(8'h3C, 0, 0, 10, 10, 20, 20));
    pending_triangles.push_back(make_triangle(8'hC3, 63, 0, 0, 63, 63, 63));
    pending_triangles.push_back(make_triangle(8'h5A, 63, 0, 0, 0, 40, 5));
    pending_triangles.push_back(make_triangle(8'hE7, 1, 7, 62, 8, 31, 9));
    pending_triangles.push_back(make_triangle(8'h18, 17, 33, 17, 34, 17, 33));
    pending_triangles.push_back(make_triangle(8'h96, 63, 63, 63, 63, 63, 63));
    pending_triangles.push_back(make_triangle(8'h69, 0, 63, 63, 62, 21, 63));
    pending_triangles.push_back(make_triangle(8'h0F, 42, 21, 21, 42, 63, 0));
    pending_triangles.push_back(make_triangle(8'hF0, 2, 5, 9, 5, 4, 5));
    pending_triangles.push_back(make_triangle(8'h33, 31, 0, 32, 1, 0, 1));
    for (int i = 0; i < 35; i++) pending_triangles.push_back(random_triangle());
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 3; ph++) begin
      if (ph > 0) begin
        sender_idle_pct = (ph == 1) ? 81 : 0;
        receiver_idle_pct = (ph == 1) ? 25 : 0;
        for (int i = 0; i < 40; i++) pending_triangles.push_back(random_triangle());
      end
      while (pending_triangles.size() > 0 || in_valid || expected_spans.size() > 0)
        @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_spans.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tssf_pkg.sv
rtl/tssf_sort.sv
rtl/tssf_divider.sv
rtl/triangle_scanline_span_fill.sv
rtl/tssf_checker.sv
dv/triangle_scanline_span_fill_tb.sv
